FILE: rtl/sawa_pkg.sv
// Shared types and constants for the stop-and-wait ARQ sender.
`default_nettype none
package sawa_pkg;

  localparam int unsigned HeaderBytesDef = 8;
  localparam int unsigned PayloadMaxDef  = 512;

  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] REG_MAX_RESENDS    = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_TIMEOUT_TICKS  = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_DATA_TYPE_CODE = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_ACK_TYPE_CODE  = 2'd3;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_ACK    = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_GAVE_UP = 2'd1;
  localparam logic [1:0] ST_LINK    = 2'd2;

  localparam logic KIND_TX_REQUEST = 1'b0;
  localparam logic KIND_DONE       = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] payload_length;
    logic [9:0]  sent_bytes;
    logic        link_error;
    logic [9:0]  ack_bytes;
    logic [7:0]  ack_kind;
    logic [7:0]  ack_number;
  } req_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       tx_sequence;
    logic [7:0] tx_type;
    logic [9:0] tx_length;
    logic [1:0] status;
    logic [9:0] delivered_length;
  } res_item_t;

  // handshake between the decision logic and the output register
  typedef struct packed {
    logic      valid;
    res_item_t item;
  } res_slot_t;

endpackage
`default_nettype wire

FILE: rtl/sawa_ifs.sv
// Request and result channel interfaces.
`default_nettype none
interface sawa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] payload_length;
  logic [9:0]  sent_bytes;
  logic        link_error;
  logic [9:0]  ack_bytes;
  logic [7:0]  ack_kind;
  logic [7:0]  ack_number;

  modport source (output valid, command, payload_length, sent_bytes, link_error,
                  ack_bytes, ack_kind, ack_number, input ready);
  modport sink (input valid, command, payload_length, sent_bytes, link_error,
                ack_bytes, ack_kind, ack_number, output ready);
endinterface

interface sawa_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       tx_sequence;
  logic [7:0] tx_type;
  logic [9:0] tx_length;
  logic [1:0] status;
  logic [9:0] delivered_length;

  modport source (output valid, result_kind, tx_sequence, tx_type, tx_length, status,
                  delivered_length, input ready);
  modport sink (input valid, result_kind, tx_sequence, tx_type, tx_length, status,
                delivered_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/sawa_in_reg.sv
// Input register: captures one request per cycle while not stalled.
`default_nettype none
module sawa_in_reg
  import sawa_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  sawa_req_if.sink   req,
  input  wire        advance,
  output logic       item_valid,
  output req_item_t  item
);

  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item.command        <= req.command;
      item.payload_length <= req.payload_length;
      item.sent_bytes     <= req.sent_bytes;
      item.link_error     <= req.link_error;
      item.ack_bytes      <= req.ack_bytes;
      item.ack_kind       <= req.ack_kind;
      item.ack_number     <= req.ack_number;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sawa_core.sv
// Protocol state and per-request decision logic.
`default_nettype none
module sawa_core
  import sawa_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  parameter int unsigned PAYLOAD_MAX  = PayloadMaxDef
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire [CfgIndexW-1:0]  cfg_index,
  input  wire [CfgDataW-1:0]   cfg_data,
  input  wire req_item_t       item,
  input  wire                  advance,
  output res_slot_t            res
);

  typedef enum logic [1:0] {PH_IDLE, PH_REPORT, PH_ACK} phase_t;

  localparam logic [15:0] PayloadMax  = 16'(PAYLOAD_MAX);
  localparam logic [10:0] HeaderWide  = 11'(HEADER_BYTES);
  localparam logic [9:0]  HeaderBytes = 10'(HEADER_BYTES);
  localparam logic [10:0] FrameCap    = 11'd1023;

  logic [7:0]  max_resends;
  logic [15:0] timeout_ticks;
  logic [7:0]  data_type_code;
  logic [7:0]  ack_type_code;

  phase_t      phase, phase_next;
  logic        sequence_bit, sequence_bit_next;
  logic [7:0]  resend_count, resend_count_next;
  logic [15:0] wait_timer, wait_timer_next;
  logic [9:0]  frame_length, frame_length_next;
  logic [9:0]  payload_sent, payload_sent_next;

  logic [15:0] body;
  logic [10:0] total;
  logic [9:0]  clipped;
  logic        ack_good;

  always_comb begin
    body     = (item.payload_length < PayloadMax) ? item.payload_length : PayloadMax;
    total    = HeaderWide + body[10:0];
    clipped  = (total > FrameCap) ? 10'(FrameCap) : total[9:0];
    ack_good = (item.ack_bytes >= HeaderBytes) && (item.ack_kind == ack_type_code)
               && (item.ack_number == {7'd0, sequence_bit});

    phase_next        = phase;
    sequence_bit_next = sequence_bit;
    resend_count_next = resend_count;
    wait_timer_next   = wait_timer;
    frame_length_next = frame_length;
    payload_sent_next = payload_sent;
    res               = '0;

    case (item.command)
      CMD_START: begin
        if (phase == PH_IDLE) begin
          frame_length_next = clipped;
          resend_count_next = '0;
          phase_next        = PH_REPORT;
          res.valid         = 1'b1;
          res.item.result_kind = KIND_TX_REQUEST;
          res.item.tx_sequence = sequence_bit;
          res.item.tx_type     = data_type_code;
          res.item.tx_length   = clipped;
        end
      end
      CMD_REPORT: begin
        if (phase == PH_REPORT) begin
          if (item.link_error) begin
            phase_next           = PH_IDLE;
            res.valid            = 1'b1;
            res.item.result_kind = KIND_DONE;
            res.item.status      = ST_LINK;
          end else begin
            payload_sent_next = (item.sent_bytes >= HeaderBytes)
                                ? item.sent_bytes - HeaderBytes : '0;
            wait_timer_next   = timeout_ticks;
            phase_next        = PH_ACK;
          end
        end
      end
      CMD_ACK: begin
        if (phase == PH_ACK) begin
          res.valid = 1'b1;
          if (item.link_error) begin
            phase_next           = PH_IDLE;
            res.item.result_kind = KIND_DONE;
            res.item.status      = ST_LINK;
          end else if (ack_good) begin
            sequence_bit_next         = !sequence_bit;
            phase_next                = PH_IDLE;
            res.item.result_kind      = KIND_DONE;
            res.item.status           = ST_OK;
            res.item.delivered_length = payload_sent;
          end else begin
            phase_next           = PH_REPORT;
            res.item.result_kind = KIND_TX_REQUEST;
            res.item.tx_sequence = sequence_bit;
            res.item.tx_type     = data_type_code;
            res.item.tx_length   = frame_length;
          end
        end
      end
      CMD_TICK: begin
        if (phase == PH_ACK) begin
          if (wait_timer > 16'd1) begin
            wait_timer_next = wait_timer - 16'd1;
          end else begin
            wait_timer_next = '0;
            res.valid       = 1'b1;
            if (resend_count >= max_resends) begin
              phase_next           = PH_IDLE;
              res.item.result_kind = KIND_DONE;
              res.item.status      = ST_GAVE_UP;
            end else begin
              resend_count_next    = resend_count + 8'd1;
              phase_next           = PH_REPORT;
              res.item.result_kind = KIND_TX_REQUEST;
              res.item.tx_sequence = sequence_bit;
              res.item.tx_type     = data_type_code;
              res.item.tx_length   = frame_length;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_resends    <= 8'd3;
      timeout_ticks  <= 16'd100;
      data_type_code <= 8'd0;
      ack_type_code  <= 8'd1;
      phase          <= PH_IDLE;
      sequence_bit   <= 1'b0;
      resend_count   <= '0;
      wait_timer     <= '0;
      frame_length   <= '0;
      payload_sent   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MAX_RESENDS:    max_resends    <= cfg_data[7:0];
          REG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
          REG_DATA_TYPE_CODE: data_type_code <= cfg_data[7:0];
          REG_ACK_TYPE_CODE:  ack_type_code  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        phase        <= phase_next;
        sequence_bit <= sequence_bit_next;
        resend_count <= resend_count_next;
        wait_timer   <= wait_timer_next;
        frame_length <= frame_length_next;
        payload_sent <= payload_sent_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sawa_out_reg.sv
// Result register driving the result channel.
`default_nettype none
module sawa_out_reg
  import sawa_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  input  wire res_slot_t  res,
  input  wire             advance,
  output logic            free,
  sawa_res_if.source      rsp
);

  res_item_t held;

  assign free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (free) begin
      rsp.valid <= advance && res.valid;
    end
    if (free && advance && res.valid) begin
      held <= res.item;
    end
  end

  assign rsp.result_kind      = held.result_kind;
  assign rsp.tx_sequence      = held.tx_sequence;
  assign rsp.tx_type          = held.tx_type;
  assign rsp.tx_length        = held.tx_length;
  assign rsp.status           = held.status;
  assign rsp.delivered_length = held.delivered_length;

endmodule
`default_nettype wire

FILE: rtl/stop_and_wait_arq_sender_unit.sv
// Stop-and-wait ARQ sender (alternating bit), top level.
//
// Requests arrive on the req channel (valid/ready): start, transmit report,
// acknowledgement arrived or timer tick. Each request may produce one result
// on the rsp channel: a transmit request for the link or a send completion.
// Registers are written through cfg_write/cfg_index/cfg_data, by the user only
// while idle; the block itself does not enforce this.
//
// A request is taken into an input register, decided against the protocol
// state once the output register is free, and its result (if any) lands in
// the output register. One request per cycle is sustained while rsp does not
// stall; a single pass of compare and update logic lies between the registers.
//
// When rsp stalls, the output register holds its result and the input register
// keeps its request; req.ready drops once both are occupied, and resumes as
// soon as rsp takes the pending result.
// Synchronous reset clears both registers' valid flags, the protocol state
// (idle, sequence bit 0) and restores the register defaults.
`default_nettype none
module stop_and_wait_arq_sender_unit
  import sawa_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  parameter int unsigned PAYLOAD_MAX  = PayloadMaxDef
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire [CfgIndexW-1:0] cfg_index,
  input  wire [CfgDataW-1:0]  cfg_data,
  sawa_req_if.sink            req,
  sawa_res_if.source          rsp
);

  logic      item_valid;
  req_item_t item;
  res_slot_t res;
  logic      out_free;
  logic      advance;

  assign advance = item_valid && out_free;

  sawa_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sawa_core #(
    .HEADER_BYTES (HEADER_BYTES),
    .PAYLOAD_MAX  (PAYLOAD_MAX)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .advance   (advance),
    .res       (res)
  );

  sawa_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .res     (res),
    .advance (advance),
    .free    (out_free),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire
